/* rtl/ctw_pkg.sv */
// ctw_pkg: command codes, character codes and shared types of the text console writer
// no dependencies; imported by ctw_cursor and text_console_writer
`timescale 1ns / 1ps

package ctw_pkg;

	// command codes on the cmd port
	typedef enum logic [2:0] {
		CMD_WRITE    = 3'd0,
		CMD_SET      = 3'd1,
		CMD_MOVE     = 3'd2,
		CMD_CLEAR    = 3'd3,
		CMD_CLR_LINE = 3'd4,
		CMD_CLR_REST = 3'd5,
		CMD_READ     = 3'd6,
		CMD_NOP      = 3'd7
	} cmd_t;

	// character codes
	localparam logic [7:0] CH_FIRST = 8'h20;
	localparam logic [7:0] CH_LAST  = 8'h7f;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] SPACE    = 8'h20;

	// attribute byte of every cell; writes never change it
	localparam logic [7:0] ATTR     = 8'h07;

	// store side effects of a write command
	typedef struct packed {
		logic       put;
		logic [7:0] put_char;
		logic       scroll;
	} wr_act_t;

endpackage

/* rtl/text_console_writer.sv */
// text_console_writer: text console with cursor and a character store in one memory
// depends on ctw_pkg and ctw_cursor
`timescale 1ns / 1ps

// channel   | signals                                           | handshake
// ----------+---------------------------------------------------+-------------------------
// command   | cmd, char_code, pos_col, pos_row, delta_col/_row  | transfer on start & !busy
// result    | cursor_col, cursor_row, cursor_address, cell_value | one-cycle strobe on done
//
// set, move, no-op and plain writes go straight to the report step; busy drops as done
// rises, so the next command can transfer while done is high.
// a read in range adds a wait step, for the registered memory read.
// scroll: one cell copied per cycle through the memory port, then the last row
// cleared. clears: one cell per cycle.
// after reset a clearing pass over all COLUMNS*LINES cells holds busy high.
// the receiver cannot stall; a result is shown exactly one cycle.

module text_console_writer #(
	parameter int COLUMNS   = 80,
	parameter int LINES     = 25,
	parameter int TAB_WIDTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ctw_pkg::cmd_t      cmd,
	input  logic [7:0]         char_code,
	input  logic [6:0]         pos_col,
	input  logic [4:0]         pos_row,
	input  logic signed [7:0]  delta_col,
	input  logic signed [5:0]  delta_row,
	output logic               done,
	output logic [6:0]         cursor_col,
	output logic [4:0]         cursor_row,
	output logic [10:0]        cursor_address,
	output logic [15:0]        cell_value
);
	import ctw_pkg::*;

	localparam int CELLS = COLUMNS * LINES;
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(LINES);
	localparam int AW    = $clog2(CELLS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCROLL,
		ST_DRAIN,
		ST_FILL,
		ST_RDWAIT,
		ST_REPORT
	} state_t;

	state_t        state_q;
	logic          init_q;
	logic [CW-1:0] cur_col_q;
	logic [RW-1:0] cur_row_q;
	logic [AW-1:0] scroll_rd_q;
	logic [AW-1:0] fill_addr_q;
	logic [AW-1:0] fill_end_q;
	logic [15:0]   cell_q;
	logic          cp_vld_s1;
	logic [AW-1:0] cp_addr_s1;

	logic [7:0]    mem [CELLS];
	logic [7:0]    rd_data_q;

	logic          accept;
	logic          rd_range;
	logic [AW-1:0] cur_addr;
	logic [AW-1:0] put_addr;
	logic [AW-1:0] pos_addr;
	logic [AW-1:0] row_end;
	logic [CW-1:0] nxt_col;
	logic [RW-1:0] nxt_row;
	logic [CW-1:0] put_col;
	logic [RW-1:0] put_row;
	wr_act_t       act;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	// linear cell address of a position
	function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c, input logic [RW-1:0] r);
		return AW'(c) + AW'(r) * AW'(COLUMNS);
	endfunction

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign rd_range = ({1'b0, pos_col} < 8'(COLUMNS)) && ({2'b0, pos_row} < 7'(LINES));
	assign cur_addr = cell_addr(cur_col_q, cur_row_q);
	assign put_addr = cell_addr(put_col, put_row);
	assign pos_addr = cell_addr(CW'(pos_col), RW'(pos_row));
	assign row_end  = cell_addr(CW'(COLUMNS - 1), cur_row_q);

	// cursor update and store effects of the command
	ctw_cursor #(
		.COLUMNS   (COLUMNS),
		.LINES     (LINES),
		.TAB_WIDTH (TAB_WIDTH)
	) u_cursor (
		.cmd       (cmd),
		.char_code (char_code),
		.pos_col   (pos_col),
		.pos_row   (pos_row),
		.delta_col (delta_col),
		.delta_row (delta_row),
		.col       (cur_col_q),
		.row       (cur_row_q),
		.nxt_col   (nxt_col),
		.nxt_row   (nxt_row),
		.put_col   (put_col),
		.put_row   (put_row),
		.act       (act)
	);

	// write port: cell put on transfer, scroll copy, or clearing sweep
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = fill_addr_q;
		wr_data = SPACE;
		if (accept && cmd == CMD_WRITE && act.put) begin
			wr_en   = 1'b1;
			wr_addr = put_addr;
			wr_data = act.put_char;
		end else if (cp_vld_s1) begin
			wr_en   = 1'b1;
			wr_addr = cp_addr_s1;
			wr_data = rd_data_q;
		end else if (state_q == ST_FILL) begin
			wr_en   = 1'b1;
		end
	end

	// read port: cell read command, or the source row of a scroll copy
	// the copy reads one row ahead of its writes, so no entry is read after being written
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = scroll_rd_q;
		if (accept && cmd == CMD_READ && rd_range) begin
			rd_en   = 1'b1;
			rd_addr = pos_addr;
		end else if (state_q == ST_SCROLL) begin
			rd_en   = 1'b1;
		end
	end

	// character store
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	// sequencer, cursor and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_FILL;
			init_q         <= 1'b1;
			cur_col_q      <= '0;
			cur_row_q      <= '0;
			scroll_rd_q    <= '0;
			fill_addr_q    <= '0;
			fill_end_q     <= AW'(CELLS - 1);
			cell_q         <= '0;
			cp_vld_s1      <= 1'b0;
			cp_addr_s1     <= '0;
			done           <= 1'b0;
			cursor_col     <= '0;
			cursor_row     <= '0;
			cursor_address <= '0;
			cell_value     <= '0;
		end else begin
			cp_vld_s1  <= (state_q == ST_SCROLL);
			cp_addr_s1 <= scroll_rd_q - AW'(COLUMNS);
			done       <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cell_q    <= '0;
						cur_col_q <= nxt_col;
						cur_row_q <= nxt_row;
						case (cmd)
							CMD_WRITE: begin
								scroll_rd_q <= AW'(COLUMNS);
								state_q     <= act.scroll ? ST_SCROLL : ST_REPORT;
							end
							CMD_CLEAR: begin
								fill_addr_q <= '0;
								fill_end_q  <= AW'(CELLS - 1);
								state_q     <= ST_FILL;
							end
							CMD_CLR_LINE: begin
								fill_addr_q <= cur_addr + 1'b1;
								fill_end_q  <= row_end;
								state_q     <= (cur_col_q == CW'(COLUMNS - 1)) ? ST_REPORT : ST_FILL;
							end
							CMD_CLR_REST: begin
								fill_addr_q <= cur_addr + 1'b1;
								fill_end_q  <= AW'(CELLS - 1);
								state_q     <= (cur_addr == AW'(CELLS - 1)) ? ST_REPORT : ST_FILL;
							end
							CMD_READ: begin
								state_q <= rd_range ? ST_RDWAIT : ST_REPORT;
							end
							default: begin
								state_q <= ST_REPORT;
							end
						endcase
					end
				end
				// copy rows up by one, one cell per cycle
				ST_SCROLL: begin
					scroll_rd_q <= scroll_rd_q + 1'b1;
					if (scroll_rd_q == AW'(CELLS - 1))
						state_q <= ST_DRAIN;
				end
				// last copy lands, then blank the bottom row
				ST_DRAIN: begin
					fill_addr_q <= AW'(CELLS - COLUMNS);
					fill_end_q  <= AW'(CELLS - 1);
					state_q     <= ST_FILL;
				end
				// write spaces over a range of cells
				ST_FILL: begin
					fill_addr_q <= fill_addr_q + 1'b1;
					if (fill_addr_q == fill_end_q) begin
						init_q  <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_REPORT;
					end
				end
				ST_RDWAIT: begin
					cell_q  <= {ATTR, rd_data_q};
					state_q <= ST_REPORT;
				end
				// present the result for one cycle
				ST_REPORT: begin
					done           <= 1'b1;
					cursor_col     <= 7'(cur_col_q);
					cursor_row     <= 5'(cur_row_q);
					cursor_address <= 11'(cur_addr);
					cell_value     <= cell_q;
					state_q        <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// a result strobe follows only the report step
	a_done_after_report: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_REPORT))
		else $error("result strobe without report step");

	// no command is taken during the clearing pass after reset
	a_busy_while_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> busy)
		else $error("command taken during clearing pass");

	// scroll copies never target the bottom row
	a_copy_above_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		cp_vld_s1 |-> (cp_addr_s1 < AW'(CELLS - COLUMNS)))
		else $error("scroll copy into bottom row");

	// cursor stays on the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_col_q <= CW'(COLUMNS - 1)) && (cur_row_q <= RW'(LINES - 1)))
		else $error("cursor off screen");
`endif

endmodule

/* rtl/ctw_cursor.sv */
// ctw_cursor: next cursor position and cell update for one command
// depends on ctw_pkg
`timescale 1ns / 1ps

module ctw_cursor #(
	parameter int COLUMNS   = 80,
	parameter int LINES     = 25,
	parameter int TAB_WIDTH = 8
) (
	input  ctw_pkg::cmd_t               cmd,
	input  logic [7:0]                  char_code,
	input  logic [6:0]                  pos_col,
	input  logic [4:0]                  pos_row,
	input  logic signed [7:0]           delta_col,
	input  logic signed [5:0]           delta_row,
	input  logic [$clog2(COLUMNS)-1:0]  col,
	input  logic [$clog2(LINES)-1:0]    row,
	output logic [$clog2(COLUMNS)-1:0]  nxt_col,
	output logic [$clog2(LINES)-1:0]    nxt_row,
	output logic [$clog2(COLUMNS)-1:0]  put_col,
	output logic [$clog2(LINES)-1:0]    put_row,
	output ctw_pkg::wr_act_t            act
);
	import ctw_pkg::*;

	localparam int CW        = $clog2(COLUMNS);
	localparam int RW        = $clog2(LINES);
	localparam int TAB_STOPS = COLUMNS / TAB_WIDTH + 1;
	localparam logic signed [9:0] COL_TOP = 10'(COLUMNS - 1);
	localparam logic signed [7:0] ROW_TOP = 8'(LINES - 1);

	logic                 last_col;
	logic                 bottom;
	logic [RW-1:0]        nl_row;
	logic [7:0]           tab_col;
	logic signed [9:0]    col_sum;
	logic signed [7:0]    row_sum;

	// line end, bottom row and the row a new line goes to
	assign last_col = (col == CW'(COLUMNS - 1));
	assign bottom   = (row == RW'(LINES - 1));
	assign nl_row   = bottom ? row : row + 1'b1;

	// signed sums for the move command
	assign col_sum = $signed(10'(col)) + 10'(delta_col);
	assign row_sum = $signed(8'(row)) + 8'(delta_row);

	// next tab stop: smallest multiple of the tab width above the column
	always_comb begin
		tab_col = 8'(TAB_STOPS * TAB_WIDTH);
		for (int k = TAB_STOPS; k >= 1; k--) begin
			if (8'(k * TAB_WIDTH) > 8'(col))
				tab_col = 8'(k * TAB_WIDTH);
		end
	end

	// command decode
	always_comb begin
		nxt_col      = col;
		nxt_row      = row;
		act          = '0;
		act.put_char = SPACE;
		case (cmd)
			CMD_WRITE: begin
				if (char_code inside {[CH_FIRST:CH_LAST]}) begin
					act.put      = 1'b1;
					act.put_char = char_code;
					if (last_col) begin
						nxt_col    = '0;
						nxt_row    = nl_row;
						act.scroll = bottom;
					end else begin
						nxt_col = col + 1'b1;
					end
				end else if (char_code == CH_NL) begin
					nxt_col    = '0;
					nxt_row    = nl_row;
					act.scroll = bottom;
				end else if (char_code == CH_TAB) begin
					if (tab_col >= 8'(COLUMNS)) begin
						nxt_col    = '0;
						nxt_row    = nl_row;
						act.scroll = bottom;
					end else begin
						nxt_col = CW'(tab_col);
					end
				end else if (char_code == CH_BS) begin
					act.put = 1'b1;
					if (col == '0) begin
						if (row != '0) begin
							nxt_col = CW'(COLUMNS - 1);
							nxt_row = row - 1'b1;
						end
					end else begin
						nxt_col = col - 1'b1;
					end
				end
			end
			CMD_SET: begin
				nxt_col = ({1'b0, pos_col} < 8'(COLUMNS)) ? CW'(pos_col) : CW'(COLUMNS - 1);
				nxt_row = ({2'b0, pos_row} < 7'(LINES)) ? RW'(pos_row) : RW'(LINES - 1);
			end
			CMD_MOVE: begin
				if (col_sum < 10'sd0)
					nxt_col = '0;
				else if (col_sum > COL_TOP)
					nxt_col = CW'(COLUMNS - 1);
				else
					nxt_col = CW'(col_sum);
				if (row_sum < 8'sd0)
					nxt_row = '0;
				else if (row_sum > ROW_TOP)
					nxt_row = RW'(LINES - 1);
				else
					nxt_row = RW'(row_sum);
			end
			CMD_CLEAR: begin
				nxt_col = '0;
				nxt_row = '0;
			end
			default: begin
			end
		endcase
	end

	// printable goes under the old cursor, backspace erases under the new one
	assign put_col = (char_code == CH_BS) ? nxt_col : col;
	assign put_row = (char_code == CH_BS) ? nxt_row : row;

endmodule
